>>> rtl/core/rv64m_multiply_divide_unit_defines.svh
// ----------------------------------------------------------------------------
// RV64M multiply/divide unit assertion macros
// Shared concurrent assertion forms for the unit's checker.
// ----------------------------------------------------------------------------
`ifndef RV64M_MULTIPLY_DIVIDE_UNIT_DEFINES_SVH
`define RV64M_MULTIPLY_DIVIDE_UNIT_DEFINES_SVH

// antecedent implies consequent on the next clock
`define MDU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// antecedent implies consequent on the same clock
`define MDU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rvmdu_pkg.sv
// ----------------------------------------------------------------------------
// RV64M multiply/divide unit package
// Operation codes, widths and stage record types.
// ----------------------------------------------------------------------------
`default_nettype none

package rvmdu_pkg;

    localparam int unsigned XLEN = 64;
    localparam int unsigned WLEN = 32;
    localparam int unsigned FUNC_W = 4;
    localparam int unsigned CNT_W = 7;

    typedef enum logic [FUNC_W-1:0] {
        FN_MUL    = 4'd0,
        FN_MULH   = 4'd1,
        FN_MULHSU = 4'd2,
        FN_MULHU  = 4'd3,
        FN_DIV    = 4'd4,
        FN_DIVU   = 4'd5,
        FN_REM    = 4'd6,
        FN_REMU   = 4'd7,
        FN_MULW   = 4'd8,
        FN_DIVW   = 4'd9,
        FN_DIVUW  = 4'd10,
        FN_REMW   = 4'd11,
        FN_REMUW  = 4'd12
    } func_t;

    // decoded request, travels with the data
    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic word;
        logic want_hi;   // mul: high half; div: remainder
        logic neg_res;   // mul: negate product; div: negate quotient
        logic neg_rem;
        logic special;   // divide by zero or overflow: fixed answer
        logic illegal;
    } ctl_t;

    typedef struct packed {
        logic       valid;
        ctl_t       ctl;
        logic [XLEN-1:0] fixed;     // answer for special cases
    } tag_t;

endpackage

`default_nettype wire

>>> rtl/core/rvmdu_decode.sv
// ----------------------------------------------------------------------------
// RV64M decode stage
// Classifies the request, takes operand magnitudes, resolves special cases.
// ----------------------------------------------------------------------------
`default_nettype none

module rvmdu_decode (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              en,
    input  wire logic                              in_valid,
    input  wire logic [rvmdu_pkg::FUNC_W-1:0]      func,
    input  wire logic [rvmdu_pkg::XLEN-1:0]        operand_a,
    input  wire logic [rvmdu_pkg::XLEN-1:0]        operand_b,
    output rvmdu_pkg::tag_t                        tag,
    output logic [rvmdu_pkg::XLEN-1:0]             mag_a,
    output logic [rvmdu_pkg::XLEN-1:0]             mag_b
);

    rvmdu_pkg::tag_t tag_next;
    logic valid_reg;
    rvmdu_pkg::ctl_t ctl_reg;
    logic [rvmdu_pkg::XLEN-1:0] fixed_reg;
    logic [rvmdu_pkg::XLEN-1:0] mag_a_reg, mag_a_next, mag_b_reg, mag_b_next;

    always_comb
    begin
        logic [rvmdu_pkg::XLEN-1:0] a, b;
        logic sa, sb, sgn_a, sgn_b, zero_b, ovf;
        a = operand_a;
        b = operand_b;
        sgn_a = 1'b0;
        sgn_b = 1'b0;
        tag_next = '0;
        tag_next.valid = in_valid;
        case (func)
            rvmdu_pkg::FN_MUL:    begin tag_next.ctl.is_mul = 1'b1; end
            rvmdu_pkg::FN_MULH:
            begin
                tag_next.ctl.is_mul = 1'b1; tag_next.ctl.want_hi = 1'b1;
                sgn_a = 1'b1; sgn_b = 1'b1;
            end
            rvmdu_pkg::FN_MULHSU:
            begin
                tag_next.ctl.is_mul = 1'b1; tag_next.ctl.want_hi = 1'b1; sgn_a = 1'b1;
            end
            rvmdu_pkg::FN_MULHU:  begin tag_next.ctl.is_mul = 1'b1; tag_next.ctl.want_hi = 1'b1; end
            rvmdu_pkg::FN_DIV:    begin tag_next.ctl.is_div = 1'b1; sgn_a = 1'b1; sgn_b = 1'b1; end
            rvmdu_pkg::FN_DIVU:   begin tag_next.ctl.is_div = 1'b1; end
            rvmdu_pkg::FN_REM:
            begin
                tag_next.ctl.is_div = 1'b1; tag_next.ctl.want_hi = 1'b1;
                sgn_a = 1'b1; sgn_b = 1'b1;
            end
            rvmdu_pkg::FN_REMU:   begin tag_next.ctl.is_div = 1'b1; tag_next.ctl.want_hi = 1'b1; end
            rvmdu_pkg::FN_MULW:   begin tag_next.ctl.is_mul = 1'b1; tag_next.ctl.word = 1'b1; end
            rvmdu_pkg::FN_DIVW:
            begin
                tag_next.ctl.is_div = 1'b1; tag_next.ctl.word = 1'b1;
                sgn_a = 1'b1; sgn_b = 1'b1;
            end
            rvmdu_pkg::FN_DIVUW:  begin tag_next.ctl.is_div = 1'b1; tag_next.ctl.word = 1'b1; end
            rvmdu_pkg::FN_REMW:
            begin
                tag_next.ctl.is_div = 1'b1; tag_next.ctl.word = 1'b1;
                tag_next.ctl.want_hi = 1'b1; sgn_a = 1'b1; sgn_b = 1'b1;
            end
            rvmdu_pkg::FN_REMUW:
            begin
                tag_next.ctl.is_div = 1'b1; tag_next.ctl.word = 1'b1; tag_next.ctl.want_hi = 1'b1;
            end
            default:              begin tag_next.ctl.illegal = 1'b1; end
        endcase
        // word forms: extend the low halves (sign or zero) to full width
        if (tag_next.ctl.word)
        begin
            a = {{rvmdu_pkg::WLEN{sgn_a & operand_a[rvmdu_pkg::WLEN-1]}},
                 operand_a[rvmdu_pkg::WLEN-1:0]};
            b = {{rvmdu_pkg::WLEN{sgn_b & operand_b[rvmdu_pkg::WLEN-1]}},
                 operand_b[rvmdu_pkg::WLEN-1:0]};
        end
        sa = sgn_a & a[rvmdu_pkg::XLEN-1];
        sb = sgn_b & b[rvmdu_pkg::XLEN-1];
        zero_b = (b == '0);
        ovf = sgn_a & sgn_b & (b == '1) &
              (tag_next.ctl.word ? (a == {{(rvmdu_pkg::XLEN-rvmdu_pkg::WLEN+1){1'b1}},
                                          {(rvmdu_pkg::WLEN-1){1'b0}}})
                                 : (a == {1'b1, {(rvmdu_pkg::XLEN-1){1'b0}}}));
        mag_a_next = sa ? (~a + 1'b1) : a;
        mag_b_next = sb ? (~b + 1'b1) : b;
        tag_next.ctl.neg_res = sa ^ sb;
        tag_next.ctl.neg_rem = sa;
        tag_next.ctl.special = tag_next.ctl.is_div & (zero_b | ovf);
        if (zero_b)
            tag_next.fixed = tag_next.ctl.want_hi ? a : '1;
        else
            tag_next.fixed = tag_next.ctl.want_hi ? '0 : a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= tag_next.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg   <= tag_next.ctl;
            fixed_reg <= tag_next.fixed;
            mag_a_reg <= mag_a_next;
            mag_b_reg <= mag_b_next;
        end
    end

    assign tag   = {valid_reg, ctl_reg, fixed_reg};
    assign mag_a = mag_a_reg;
    assign mag_b = mag_b_reg;

endmodule

`default_nettype wire

>>> rtl/core/rvmdu_mul_pipe.sv
// ----------------------------------------------------------------------------
// RV64M multiplier pipeline
// Four 32x32 partial products, registered, then summed and sign-corrected.
// ----------------------------------------------------------------------------
`default_nettype none

module rvmdu_mul_pipe (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [rvmdu_pkg::XLEN-1:0]    mag_a,
    input  wire logic [rvmdu_pkg::XLEN-1:0]    mag_b,
    input  wire logic                          neg,
    output logic [2*rvmdu_pkg::XLEN-1:0]       product
);

    localparam int unsigned H = rvmdu_pkg::WLEN;

    logic [2*H-1:0] ll_reg, lh_reg, hl_reg, hh_reg;
    logic neg_reg, neg2_reg;
    logic [2*rvmdu_pkg::XLEN-1:0] sum_reg, sum_next, prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg  <= mag_a[H-1:0] * mag_b[H-1:0];
            lh_reg  <= mag_a[H-1:0] * mag_b[2*H-1:H];
            hl_reg  <= mag_a[2*H-1:H] * mag_b[H-1:0];
            hh_reg  <= mag_a[2*H-1:H] * mag_b[2*H-1:H];
            neg_reg <= neg;
        end
    end

    always_comb
    begin
        sum_next = {hh_reg, ll_reg}
                 + {{H{1'b0}}, lh_reg, {H{1'b0}}}
                 + {{H{1'b0}}, hl_reg, {H{1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg  <= sum_next;
            neg2_reg <= neg_reg;
            prod_reg <= neg2_reg ? (~sum_reg + 1'b1) : sum_reg;
        end
    end

    assign product = prod_reg;

endmodule

`default_nettype wire

>>> rtl/core/rvmdu_div_pipe.sv
// ----------------------------------------------------------------------------
// RV64M divider pipeline
// Restoring division, one quotient bit per stage, 64 stages of magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module rvmdu_div_pipe (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [rvmdu_pkg::XLEN-1:0]    mag_a,
    input  wire logic [rvmdu_pkg::XLEN-1:0]    mag_b,
    output logic [rvmdu_pkg::XLEN-1:0]         quot,
    output logic [rvmdu_pkg::XLEN-1:0]         rem
);

    localparam int unsigned N = rvmdu_pkg::XLEN;

    // stage k holds partial remainder, shifting dividend/quotient, divisor
    logic [N-1:0] rem_reg [N+1];
    logic [N-1:0] dq_reg  [N+1];
    logic [N-1:0] dvs_reg [N+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= '0;
            dq_reg[0]  <= mag_a;
            dvs_reg[0] <= mag_b;
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic [N:0] trial;
        logic [N:0] diff;
        always_comb
        begin
            trial = {rem_reg[k], dq_reg[k][N-1]};
            diff  = trial - {1'b0, dvs_reg[k]};
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= diff[N] ? trial[N-1:0] : diff[N-1:0];
                dq_reg[k+1]  <= {dq_reg[k][N-2:0], ~diff[N]};
                dvs_reg[k+1] <= dvs_reg[k];
            end
        end
    end

    assign quot = dq_reg[N];
    assign rem  = rem_reg[N];

endmodule

`default_nettype wire

>>> rtl/core/rv64m_multiply_divide_unit.sv
// ----------------------------------------------------------------------------
// RV64M multiply/divide unit
// Fully pipelined M-extension unit for a 64-bit core.
// ----------------------------------------------------------------------------
// One request may enter every cycle unless in_stall is high; results come out in
// order through the decode register, divider input register, 64 divider stages
// and output register (the sign fix sits ahead of the output register) of the
// one-bit-per-stage divider array; multiplies are delayed to the same path length.
// A stall freezes the whole pipeline, so nothing is lost or repeated.
`default_nettype none

module rv64m_multiply_divide_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [rvmdu_pkg::FUNC_W-1:0]  func,
    input  wire logic [rvmdu_pkg::XLEN-1:0]    operand_a,
    input  wire logic [rvmdu_pkg::XLEN-1:0]    operand_b,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [rvmdu_pkg::XLEN-1:0]         result,
    output logic                               illegal
);

    localparam int unsigned N = rvmdu_pkg::XLEN;
    localparam int unsigned MUL_LAT = 3;

    logic en;
    rvmdu_pkg::tag_t dec_tag;
    logic [N-1:0] mag_a, mag_b, quot, rem;
    logic [2*N-1:0] product;

    // tag line alongside the divider array, one entry per divider register
    logic            vld_reg   [N+1];
    rvmdu_pkg::ctl_t ctl_reg   [N+1];
    logic [N-1:0]    fixed_reg [N+1];
    logic [2*N-1:0] prod_reg [N-MUL_LAT+1];
    logic [N-1:0] res_reg, res_next;
    logic out_valid_reg, illegal_reg;

    // the pipeline moves unless its last stage holds an untaken result
    assign en = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    rvmdu_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .func      (func),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .tag       (dec_tag),
        .mag_a     (mag_a),
        .mag_b     (mag_b)
    );

    rvmdu_mul_pipe u_mul (
        .clk     (clk),
        .en      (en),
        .mag_a   (mag_a),
        .mag_b   (mag_b),
        .neg     (dec_tag.ctl.neg_res),
        .product (product)
    );

    rvmdu_div_pipe u_div (
        .clk   (clk),
        .en    (en),
        .mag_a (mag_a),
        .mag_b (mag_b),
        .quot  (quot),
        .rem   (rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= N; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= dec_tag.valid;
            for (int i = 1; i <= N; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg[0]   <= dec_tag.ctl;
            fixed_reg[0] <= dec_tag.fixed;
            for (int i = 1; i <= N; i++)
            begin
                ctl_reg[i]   <= ctl_reg[i-1];
                fixed_reg[i] <= fixed_reg[i-1];
            end
            prod_reg[0] <= product;
            for (int i = 1; i <= N - MUL_LAT; i++)
                prod_reg[i] <= prod_reg[i-1];
        end
    end

    always_comb
    begin
        rvmdu_pkg::ctl_t c;
        logic [N-1:0] r;
        c = ctl_reg[N];
        if (c.illegal)
            r = '0;
        else if (c.special)
            r = fixed_reg[N];
        else if (c.is_mul)
            r = c.want_hi ? prod_reg[N-MUL_LAT][2*N-1:N] : prod_reg[N-MUL_LAT][N-1:0];
        else if (c.want_hi)
            r = c.neg_rem ? (~rem + 1'b1) : rem;
        else
            r = c.neg_res ? (~quot + 1'b1) : quot;
        if (c.word)
            res_next = {{(N-rvmdu_pkg::WLEN){r[rvmdu_pkg::WLEN-1]}}, r[rvmdu_pkg::WLEN-1:0]};
        else
            res_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vld_reg[N];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg     <= res_next;
            illegal_reg <= ctl_reg[N].illegal;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;
    assign illegal   = illegal_reg;

endmodule

`default_nettype wire

>>> rtl/core/rvmdu_checker.sv
// ----------------------------------------------------------------------------
// RV64M multiply/divide unit port checker
// Watches the unit's ports and flags handshake and result slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rv64m_multiply_divide_unit_defines.svh"

module rvmdu_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_stall,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic [rvmdu_pkg::XLEN-1:0]    result,
    input  wire logic                          illegal
);

    `MDU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(result) && $stable(illegal), "stalled result changed")
    `MDU_ASSERT_SAME(a_illegal_zero, clk, rst_n, out_valid && illegal, result == '0, "illegal request gave nonzero result")
    `MDU_ASSERT_SAME(a_stall_only_when_full, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without output backpressure")
    `MDU_ASSERT_SAME(a_free_flow, clk, rst_n, !out_stall, !in_stall, "input stalled with no output stall")

endmodule

bind rv64m_multiply_divide_unit rvmdu_checker u_rvmdu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result),
    .illegal   (illegal)
);

`default_nettype wire
